@@ rtl/core/bacc_pkg.sv @@
// Shared types and constants for the boom angle cross-check block.
package bacc_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_LEARNING = 2'd0,
    ST_OK       = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  // Configuration register indexes.
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_REFERENCE_ANGLE   = 3'd0;
  localparam reg_idx_t REG_INITIAL_DIRECTION = 3'd1;
  localparam reg_idx_t REG_LEARN_THRESHOLD   = 3'd2;
  localparam reg_idx_t REG_MIN_ENCODER_MOVE  = 3'd3;
  localparam reg_idx_t REG_TOLERANCE         = 3'd4;
  localparam reg_idx_t REG_HOLD_TIME_MS      = 3'd5;

  // Configuration write data width.
  localparam int unsigned CfgDataW = 16;

  // Direction sign codes.
  typedef logic signed [1:0] dir_t;
  localparam dir_t DIR_UNKNOWN = 2'sb00;
  localparam dir_t DIR_POS     = 2'sb01;
  localparam dir_t DIR_NEG     = 2'sb11;

  // Register reset values.
  localparam logic [14:0] LEARN_THRESHOLD_RST  = 15'd500;
  localparam logic [14:0] MIN_ENCODER_MOVE_RST = 15'd200;
  localparam logic [15:0] TOLERANCE_RST        = 16'd300;
  localparam logic [15:0] HOLD_TIME_MS_RST     = 16'd500;

  // Angle wrap limits in 0.01 degree units, as 18 bit signed values.
  localparam logic signed [17:0] HALF_TURN     = 18'sd18000;
  localparam logic signed [17:0] NEG_HALF_TURN = -18'sd18000;
  localparam logic signed [17:0] THREE_HALF    = 18'sd54000;
  localparam logic signed [17:0] NEG_THREE_HALF = -18'sd54000;
  localparam logic signed [17:0] FULL_TURN     = 18'sd36000;
  localparam logic signed [17:0] TWO_TURNS     = 18'sd72000;

  // Sign of a 2 bit direction value; the code for minus two counts as minus one.
  function automatic dir_t dir_sign(input dir_t v);
    dir_sign = (v == 2'sb10) ? DIR_NEG : v;
  endfunction

endpackage

@@ rtl/core/bacc_in_if.sv @@
// Sample input channel: timestamp, encoder angle and IMU angle.
interface bacc_in_if;
  logic                valid;
  logic                ready;
  logic [31:0]         now_ms;
  logic [15:0]         encoder_angle;
  logic signed [15:0]  imu_angle;

  modport source (output valid, output now_ms, output encoder_angle, output imu_angle,
                  input ready);
  modport sink   (input valid, input now_ms, input encoder_angle, input imu_angle,
                  output ready);
endinterface

@@ rtl/core/bacc_out_if.sv @@
// Result channel: status, error angle, direction and learned flag.
interface bacc_out_if;
  import bacc_pkg::*;

  logic         valid;
  logic         ready;
  status_t      status;
  logic [15:0]  error_angle;
  dir_t         direction;
  logic         learned;

  modport source (output valid, output status, output error_angle, output direction,
                  output learned, input ready);
  modport sink   (input valid, input status, input error_angle, input direction,
                  input learned, output ready);
endinterface

@@ rtl/core/bacc_cfg_if.sv @@
// Configuration write channel: register index and write data.
interface bacc_cfg_if;
  import bacc_pkg::*;

  logic                  valid;
  logic                  ready;
  reg_idx_t              reg_index;
  logic [CfgDataW-1:0]   wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ rtl/core/boom_angle_cross_check.sv @@
// Boom angle cross-check: compares encoder and IMU boom angles per sample.
//
// Usage:
//   in_chan carries one sample per transfer: a millisecond timestamp, the
//   absolute encoder angle and the IMU boom angle (0.01 degree units).
//   out_chan returns exactly one result per sample: status, error angle,
//   direction in use and the learned flag, in sample order.
//   cfg_chan writes the six setup registers; it is always ready, and any
//   write to a listed register restarts direction learning. Write it only
//   while no sample is in flight.
// Timing:
//   A sample is registered in the input register and its result in the output
//   register, where it waits until taken. The input register accepts one
//   sample per cycle while the receiver does not stall: the whole check is one
//   pass of compare and subtract logic between the two registers, and the
//   running state is updated in the same cycle as the output register.
// Reset and stalls:
//   Reset empties both registers, loads the register defaults and clears the
//   learned state. When the receiver stalls, the waiting result holds and
//   one more sample is still taken into the input register if it is empty.
module boom_angle_cross_check (
  input  logic   clk,
  input  logic   rst_n,
  bacc_in_if.sink    in_chan,
  bacc_out_if.source out_chan,
  bacc_cfg_if.sink   cfg_chan
);
  import bacc_pkg::*;

  // Configuration registers.
  logic [15:0] ref_angle_r;
  dir_t        init_dir_r;
  logic [14:0] learn_thr_r;
  logic [14:0] min_move_r;
  logic [15:0] tol_r;
  logic [15:0] hold_r;

  // Running state.
  dir_t        dir_r,        dir_nxt;
  logic        learned_r,    learned_nxt;
  logic        disagree_r,   disagree_nxt;
  logic [31:0] start_r,      start_nxt;

  // Input stage.
  logic               s1_valid_r;
  logic [31:0]        now_r;
  logic [15:0]        enc_r;
  logic signed [15:0] imu_r;

  // Output stage.
  logic        out_valid_r;
  status_t     out_status_r;
  logic [15:0] out_err_r;
  dir_t        out_dir_r;
  logic        out_learned_r;

  // Handshake and datapath signals.
  logic               in_xfer, adv;
  logic               cfg_xfer, cfg_restart;
  dir_t               cfg_dir;
  logic signed [17:0] d_raw, d_wrap;
  logic signed [15:0] delta;
  logic [15:0]        delta_neg;
  logic [14:0]        abs_delta;
  logic [15:0]        imu_neg;
  logic [15:0]        abs_imu;
  logic               below_thr, moved, learn_now, same_sign;
  dir_t               dir_eff;
  logic signed [17:0] dir_delta, err_s, err_neg;
  logic [15:0]        abs_err;
  logic [31:0]        elapsed;
  logic               candidate;
  status_t            status_nxt;
  status_t            hold_status;
  logic [15:0]        err_nxt;

  // Channel handshakes: the input register refills whenever it empties.
  assign adv            = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || adv;
  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign cfg_xfer       = cfg_chan.valid && cfg_chan.ready;

  // Configuration decode: which writes restart learning and the new direction.
  always_comb begin
    cfg_restart = 1'b0;
    cfg_dir     = dir_sign(init_dir_r);
    unique case (cfg_chan.reg_index)
      REG_INITIAL_DIRECTION: begin
        cfg_restart = cfg_xfer;
        cfg_dir     = dir_sign(dir_t'(cfg_chan.wdata[1:0]));
      end
      REG_REFERENCE_ANGLE, REG_LEARN_THRESHOLD, REG_MIN_ENCODER_MOVE,
      REG_TOLERANCE, REG_HOLD_TIME_MS: begin
        cfg_restart = cfg_xfer;
      end
      default: begin
        cfg_restart = 1'b0;
      end
    endcase
  end

  // Encoder offset from the reference, wrapped into the range above minus and up to plus half a turn.
  always_comb begin
    d_raw = $signed({2'b00, enc_r}) - $signed({2'b00, ref_angle_r});
    if (d_raw > THREE_HALF) begin
      d_wrap = d_raw - TWO_TURNS;
    end else if (d_raw > HALF_TURN) begin
      d_wrap = d_raw - FULL_TURN;
    end else if (d_raw <= NEG_THREE_HALF) begin
      d_wrap = d_raw + TWO_TURNS;
    end else if (d_raw <= NEG_HALF_TURN) begin
      d_wrap = d_raw + FULL_TURN;
    end else begin
      d_wrap = d_raw;
    end
    delta     = d_wrap[15:0];
    delta_neg = 16'(-delta);
    abs_delta = delta[15] ? delta_neg[14:0] : delta[14:0];
    imu_neg   = 16'(-imu_r);
    abs_imu   = imu_r[15] ? imu_neg : imu_r;
  end

  // Direction learning and the error against the IMU angle.
  always_comb begin
    below_thr = (dir_r == DIR_UNKNOWN) && (abs_imu < {1'b0, learn_thr_r});
    moved     = abs_delta >= min_move_r;
    learn_now = (dir_r == DIR_UNKNOWN) && !below_thr && moved;
    same_sign = ((delta > 16'sd0) && (imu_r > 16'sd0)) ||
                ((delta < 16'sd0) && (imu_r < 16'sd0));
    dir_eff   = learn_now ? (same_sign ? DIR_POS : DIR_NEG) : dir_r;
    dir_delta = dir_eff[1] ? -18'(delta) : 18'(delta);
    err_s     = dir_delta - 18'(imu_r);
    err_neg   = -err_s;
    abs_err   = err_s[17] ? err_neg[15:0] : err_s[15:0];
  end

  // Disagreement tracking and the result status.
  always_comb begin
    dir_nxt      = dir_eff;
    learned_nxt  = learned_r || learn_now;
    disagree_nxt = disagree_r;
    start_nxt    = start_r;
    candidate    = 1'b0;
    err_nxt      = 16'd0;
    elapsed      = disagree_r ? (now_r - start_r) : 32'd0;
    hold_status  = (dir_eff == DIR_UNKNOWN) ? ST_LEARNING : ST_OK;
    status_nxt   = hold_status;
    if (below_thr) begin
      // Boom near its rest position: nothing to compare yet.
      disagree_nxt = 1'b0;
      status_nxt   = ST_LEARNING;
    end else begin
      if (dir_eff != DIR_UNKNOWN) begin
        err_nxt   = abs_err;
        candidate = abs_err > tol_r;
      end else begin
        // The IMU shows a large angle but the encoder has not followed.
        err_nxt   = abs_imu;
        candidate = 1'b1;
      end
      if (!candidate) begin
        disagree_nxt = 1'b0;
      end else begin
        disagree_nxt = 1'b1;
        if (!disagree_r) begin
          start_nxt = now_r;
        end
        if (elapsed >= {16'd0, hold_r}) begin
          status_nxt = ST_MISMATCH;
        end
      end
    end
  end

  // Control registers, configuration and running state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ref_angle_r <= 16'd0;
      init_dir_r  <= DIR_UNKNOWN;
      learn_thr_r <= LEARN_THRESHOLD_RST;
      min_move_r  <= MIN_ENCODER_MOVE_RST;
      tol_r       <= TOLERANCE_RST;
      hold_r      <= HOLD_TIME_MS_RST;
      dir_r       <= DIR_UNKNOWN;
      learned_r   <= 1'b0;
      disagree_r  <= 1'b0;
      start_r     <= 32'd0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_xfer) begin
        unique case (cfg_chan.reg_index)
          REG_REFERENCE_ANGLE:   ref_angle_r <= cfg_chan.wdata;
          REG_INITIAL_DIRECTION: init_dir_r  <= dir_t'(cfg_chan.wdata[1:0]);
          REG_LEARN_THRESHOLD:   learn_thr_r <= cfg_chan.wdata[14:0];
          REG_MIN_ENCODER_MOVE:  min_move_r  <= cfg_chan.wdata[14:0];
          REG_TOLERANCE:         tol_r       <= cfg_chan.wdata;
          REG_HOLD_TIME_MS:      hold_r      <= cfg_chan.wdata;
          default: begin
          end
        endcase
      end

      // A configuration write restarts learning; the start time is kept.
      if (cfg_restart) begin
        dir_r      <= cfg_dir;
        learned_r  <= 1'b0;
        disagree_r <= 1'b0;
      end else if (adv) begin
        dir_r      <= dir_nxt;
        learned_r  <= learned_nxt;
        disagree_r <= disagree_nxt;
        start_r    <= start_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r <= in_chan.now_ms;
      enc_r <= in_chan.encoder_angle;
      imu_r <= in_chan.imu_angle;
    end
    if (adv) begin
      out_status_r  <= status_nxt;
      out_err_r     <= err_nxt;
      out_dir_r     <= dir_nxt;
      out_learned_r <= learned_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.error_angle = out_err_r;
  assign out_chan.direction   = out_dir_r;
  assign out_chan.learned     = out_learned_r;

  // A learned direction is always a known one.
  a_learned_known: assert property (@(posedge clk) disable iff (!rst_n)
    learned_r |-> (dir_r != DIR_UNKNOWN))
    else $error("learned flag set with unknown direction");

  // A restarting configuration write clears the learned and disagreement state.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_restart |=> (!learned_r && !disagree_r))
    else $error("configuration write did not restart learning");

  // A mismatch result leaves a disagreement in progress.
  a_mismatch_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg_restart && (status_nxt == ST_MISMATCH)) |=> disagree_r)
    else $error("mismatch reported without a disagreement in progress");

  // With no known direction the result is never reported as ok.
  a_unknown_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_dir_r == DIR_UNKNOWN)) |-> (out_status_r != ST_OK))
    else $error("ok status with unknown direction");

endmodule
